>>> hw/rtl/stps_pkg.sv
// Shared constants, command codes and result layout of the serial test statistics unit.
`timescale 1ns / 1ps
package stps_pkg;
	localparam int MAX_PATTERN_DEF   = 12;
	localparam int MAX_BITS_LOG2_DEF = 20;
	localparam int QUEUE_DEPTH       = 4;
	localparam logic [3:0] PATTERN_LENGTH_RST = 4'd3;

	localparam logic CMD_INC = 1'b0;
	localparam logic CMD_END = 1'b1;

	localparam int TDATA_IN_W  = 8;
	localparam int TDATA_OUT_W = 296;

	// last field in the lowest bits: packed struct members run from the top down
	typedef struct packed {
		logic        pad;
		logic [20:0] bit_count;
		logic [55:0] second_delta_scaled;
		logic [55:0] first_delta_scaled;
		logic [53:0] psi_m2_scaled;
		logic [53:0] psi_m1_scaled;
		logic [53:0] psi_m_scaled;
	} stps_result_t;
endpackage

>>> hw/rtl/stps_queue.sv
// Short command queue between the bit front end and the histogram back end.
`timescale 1ns / 1ps
module stps_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CNTW-1:0]  cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNTW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign dout    = slot_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

>>> hw/rtl/stps_front.sv
// Front end: take bits, track window and leading bits, issue histogram commands.
`timescale 1ns / 1ps
module stps_front #(
	parameter int MAX_PATTERN   = 12,
	parameter int MAX_BITS_LOG2 = 20,
	parameter int CMDW          = 38
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [3:0]                        pattern_length,
	input  logic                              init_done,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [stps_pkg::TDATA_IN_W-1:0]   s_tdata,  // [0] bit_value
	input  logic                              s_tlast,
	input  logic                              q_full,
	output logic                              q_push,
	output logic [CMDW-1:0]                   q_din
);
	import stps_pkg::*;

	localparam int MP = MAX_PATTERN;
	localparam int CW = MAX_BITS_LOG2 + 1;
	localparam int MW = $clog2(MP + 1);
	localparam int JW = $clog2(MP);
	localparam logic [CW-1:0] LIMIT = CW'(1) << MAX_BITS_LOG2;

	localparam logic [1:0] ST_ACC  = 2'd0;
	localparam logic [1:0] ST_WRAP = 2'd1;
	localparam logic [1:0] ST_END  = 2'd2;

	function automatic logic [MP-1:0] low_mask(input logic [MW-1:0] k);
		return ~({MP{1'b1}} << k);
	endfunction

	logic [1:0]    state_q;
	logic [MP-1:0] win_q;
	logic [MP-1:0] lead_q;
	logic [CW-1:0] seen_q;
	logic [JW-1:0] j_q;

	logic [MW-1:0] m_use;
	logic          acc;
	logic          under;
	logic [MP-1:0] win_nx;
	logic [CW-1:0] seen_nx;
	logic [MP-1:0] wrap_win;
	logic          wrap_more;

	always_comb begin
		if (pattern_length == 4'd0) begin
			m_use = MW'(1);
		end else if ({1'b0, pattern_length} > 5'(MP)) begin
			m_use = MW'(MP);
		end else begin
			m_use = MW'(pattern_length);
		end
	end

	assign s_tready  = (state_q == ST_ACC) && init_done && !q_full;
	assign acc       = s_tvalid && s_tready;
	assign under     = seen_q < LIMIT;
	assign win_nx    = {win_q[MP-2:0], s_tdata[0]};
	assign seen_nx   = seen_q + 1'b1;
	assign wrap_win  = {win_q[MP-2:0], lead_q[j_q]};
	assign wrap_more = (seen_q >= CW'(m_use)) && ((MW'(j_q) + MW'(1)) < m_use);

	always_comb begin
		q_push = 1'b0;
		q_din  = '0;
		unique case (state_q)
			ST_ACC: begin
				if (acc && under && (seen_nx >= CW'(m_use))) begin
					q_push = 1'b1;
					q_din  = {CW'(0), MW'(0), win_nx & low_mask(m_use), CMD_INC};
				end
			end
			ST_WRAP: begin
				if (wrap_more && !q_full) begin
					q_push = 1'b1;
					q_din  = {CW'(0), MW'(0), wrap_win & low_mask(m_use), CMD_INC};
				end
			end
			ST_END: begin
				if (!q_full) begin
					q_push = 1'b1;
					q_din  = {seen_q, m_use, MP'(0), CMD_END};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			win_q   <= '0;
			lead_q  <= '0;
			seen_q  <= '0;
			j_q     <= '0;
		end else begin
			unique case (state_q)
				ST_ACC: begin
					if (acc) begin
						if (under) begin
							win_q  <= win_nx;
							seen_q <= seen_nx;
							if (seen_q < CW'(MP)) begin
								lead_q[seen_q[JW-1:0]] <= s_tdata[0];
							end
						end
						if (s_tlast) begin
							state_q <= ST_WRAP;
							j_q     <= '0;
						end
					end
				end
				ST_WRAP: begin
					if (!wrap_more) begin
						state_q <= ST_END;
					end else if (!q_full) begin
						win_q <= wrap_win;
						j_q   <= j_q + 1'b1;
					end
				end
				ST_END: begin
					if (!q_full) begin
						win_q   <= '0;
						lead_q  <= '0;
						seen_q  <= '0;
						state_q <= ST_ACC;
					end
				end
				default: state_q <= ST_ACC;
			endcase
		end
	end
endmodule

>>> hw/rtl/stps_back.sv
// Back end: histogram memory, increments, end sweep with clearing, statistics, result register.
`timescale 1ns / 1ps
module stps_back #(
	parameter int MAX_PATTERN   = 12,
	parameter int MAX_BITS_LOG2 = 20,
	parameter int CMDW          = 38
) (
	input  logic                              clk,
	input  logic                              arst_n,
	output logic                              init_done,
	input  logic                              q_empty,
	input  logic [CMDW-1:0]                   q_dout,
	output logic                              q_pop,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [stps_pkg::TDATA_OUT_W-1:0]  m_tdata,
	output logic                              m_tuser
);
	import stps_pkg::*;

	localparam int MP = MAX_PATTERN;
	localparam int CW = MAX_BITS_LOG2 + 1;
	localparam int MW = $clog2(MP + 1);
	localparam int HD = 1 << MP;
	localparam int SW = 2 * CW;
	localparam int FW = (SW + MP > 56) ? SW + MP : 56;

	localparam logic [3:0] ST_CLR   = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_INCR  = 4'd2;
	localparam logic [3:0] ST_SWEEP = 4'd3;
	localparam logic [3:0] ST_DRAIN = 4'd4;
	localparam logic [3:0] ST_NSQ   = 4'd5;
	localparam logic [3:0] ST_PSI   = 4'd6;
	localparam logic [3:0] ST_DIFF  = 4'd7;
	localparam logic [3:0] ST_OUT   = 4'd8;

	function automatic logic [MP-1:0] low_mask(input logic [MW-1:0] k);
		return ~({MP{1'b1}} << k);
	endfunction

	logic [CW-1:0] hist_mem [HD];
	logic [CW-1:0] rd_q;
	logic          mem_we;
	logic [MP-1:0] mem_wa;
	logic [CW-1:0] mem_wd;
	logic          mem_re;
	logic [MP-1:0] mem_ra;

	logic [3:0]    state_q;
	logic [MP-1:0] addr_q;
	logic [MP-1:0] inc_addr_q;
	logic [CW-1:0] n_q;
	logic [MW-1:0] m_q;

	logic          cmd_kind;
	logic [MP-1:0] cmd_addr;
	logic [MW-1:0] cmd_m;
	logic [CW-1:0] cmd_n;
	logic          sweep_start;

	logic          v_s1, v_s2, v_s3;
	logic [MP-1:0] a_s1;
	logic [CW-1:0] acc1_q, acc2_q;
	logic [CW-1:0] c0_s2, c1_s2, c2_s2;
	logic          e0_s2, e1_s2, e2_s2;
	logic [SW-1:0] sq0_s3, sq1_s3, sq2_s3;
	logic [SW-1:0] sum0_q, sum1_q, sum2_q;
	logic          in_rng;
	logic [CW-1:0] c1_nx, c2_nx;

	logic [SW-1:0] nsq_q;
	logic [FW-1:0] p0_q, p1_q, p2_q, d1_q, d2_q;
	logic          short;
	stps_result_t  res;
	logic          out_free;

	assign cmd_kind    = q_dout[0];
	assign cmd_addr    = q_dout[MP:1];
	assign cmd_m       = q_dout[MP+MW:MP+1];
	assign cmd_n       = q_dout[CMDW-1:MP+MW+1];
	assign q_pop       = (state_q == ST_IDLE) && !q_empty;
	assign sweep_start = q_pop && (cmd_kind == CMD_END);
	assign init_done   = (state_q != ST_CLR);
	assign out_free    = !m_tvalid || m_tready;
	assign short       = n_q < CW'(m_q);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = addr_q;
		mem_wd = '0;
		mem_re = 1'b0;
		mem_ra = addr_q;
		unique case (state_q)
			ST_CLR: mem_we = 1'b1;
			ST_IDLE: begin
				if (q_pop && (cmd_kind == CMD_INC)) begin
					mem_re = 1'b1;
					mem_ra = cmd_addr;
				end
			end
			ST_INCR: begin
				mem_we = 1'b1;
				mem_wa = inc_addr_q;
				mem_wd = rd_q + 1'b1;
			end
			ST_SWEEP: begin
				mem_re = 1'b1;
				mem_we = 1'b1;
			end
			default: ;
		endcase
	end

	// read before write on the same address returns the old count
	always_ff @(posedge clk) begin
		if (mem_we) begin
			hist_mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= hist_mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			addr_q  <= '0;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					addr_q <= addr_q + 1'b1;
					if (&addr_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_pop) begin
						if (cmd_kind == CMD_INC) begin
							state_q <= ST_INCR;
						end else begin
							addr_q  <= '0;
							state_q <= ST_SWEEP;
						end
					end
				end
				ST_INCR: state_q <= ST_IDLE;
				ST_SWEEP: begin
					addr_q <= addr_q + 1'b1;
					if (&addr_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2 && !v_s3) begin
						state_q <= ST_NSQ;
					end
				end
				ST_NSQ:  state_q <= ST_PSI;
				ST_PSI:  state_q <= ST_DIFF;
				ST_DIFF: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			inc_addr_q <= cmd_addr;
			if (cmd_kind == CMD_END) begin
				n_q <= cmd_n;
				m_q <= cmd_m;
			end
		end
	end

	// sweep pipeline: group counts for k = m, m-1, m-2, square, accumulate
	assign in_rng = (a_s1 & ~low_mask(m_q)) == '0;
	assign c1_nx  = acc1_q + rd_q;
	assign c2_nx  = acc2_q + rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_SWEEP);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		a_s1 <= addr_q;
		if (v_s1) begin
			acc1_q <= a_s1[0] ? '0 : rd_q;
			acc2_q <= (a_s1[1:0] == 2'd3) ? '0 : c2_nx;
			c0_s2  <= rd_q;
			c1_s2  <= c1_nx;
			c2_s2  <= c2_nx;
			e0_s2  <= in_rng;
			e1_s2  <= in_rng && a_s1[0];
			e2_s2  <= in_rng && (a_s1[1:0] == 2'd3);
		end
		if (sweep_start) begin
			acc1_q <= '0;
			acc2_q <= '0;
		end
		sq0_s3 <= e0_s2 ? c0_s2 * c0_s2 : '0;
		sq1_s3 <= e1_s2 ? c1_s2 * c1_s2 : '0;
		sq2_s3 <= e2_s2 ? c2_s2 * c2_s2 : '0;
		if (sweep_start) begin
			sum0_q <= '0;
			sum1_q <= '0;
			sum2_q <= '0;
		end else if (v_s3) begin
			sum0_q <= sum0_q + sq0_s3;
			sum1_q <= sum1_q + sq1_s3;
			sum2_q <= sum2_q + sq2_s3;
		end
		if (state_q == ST_NSQ) begin
			nsq_q <= n_q * n_q;
		end
		if (state_q == ST_PSI) begin
			p0_q <= (FW'(sum0_q) << m_q) - FW'(nsq_q);
			p1_q <= (m_q >= MW'(2)) ? (FW'(sum1_q) << (m_q - 1'b1)) - FW'(nsq_q) : '0;
			p2_q <= (m_q >= MW'(3)) ? (FW'(sum2_q) << (m_q - MW'(2))) - FW'(nsq_q) : '0;
		end
		if (state_q == ST_DIFF) begin
			d1_q <= p0_q - p1_q;
			d2_q <= p0_q - (p1_q << 1) + p2_q;
		end
	end

	always_comb begin
		res                     = '0;
		res.bit_count           = 21'(n_q);
		if (!short) begin
			res.psi_m_scaled        = 54'(p0_q);
			res.psi_m1_scaled       = 54'(p1_q);
			res.psi_m2_scaled       = 54'(p2_q);
			res.first_delta_scaled  = 56'(d1_q);
			res.second_delta_scaled = 56'(d2_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if ((state_q == ST_OUT) && out_free) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && out_free) begin
			m_tdata <= res;
			m_tuser <= short;
		end
	end
endmodule

>>> hw/rtl/serial_test_pattern_statistics_unit.sv
// Top level of the serial test pattern statistics unit.
`timescale 1ns / 1ps
// Serial test statistics over a bit stream. Send one bit per request on s_tdata[0], with
// s_tlast on the final bit; one result follows each sequence. The front end takes a bit
// every cycle into a four-entry command queue while the queue is not full; the back end
// handles each histogram increment as a read, then a write of the count memory, so once
// the queue has filled a long sequence is taken only as fast as the back end drains it.
// After the last bit the front end adds m-1 wrap-around windows unless the sequence is too
// short, then the back end sweeps the whole count memory, reading and zeroing each entry,
// and passes through drain, square, psi and difference states before the result appears.
// After reset the count memory is cleared in a pass during which no bit is taken;
// configuration writes are taken at any time and should be made only between sequences.
module serial_test_pattern_statistics_unit #(
	parameter int MAX_PATTERN   = stps_pkg::MAX_PATTERN_DEF,
	parameter int MAX_BITS_LOG2 = stps_pkg::MAX_BITS_LOG2_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration: pattern_length
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [3:0]                        cfg_data,
	// bits in
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [stps_pkg::TDATA_IN_W-1:0]   s_tdata,   // [0] bit_value
	input  logic                              s_tlast,   // last_bit
	// results out
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [53:0] psi_m_scaled, [107:54] psi_m1_scaled, [161:108] psi_m2_scaled,
	// [217:162] first_delta_scaled, [273:218] second_delta_scaled, [294:274] bit_count
	output logic [stps_pkg::TDATA_OUT_W-1:0]  m_tdata,
	output logic                              m_tuser    // [0] too_short
);
	import stps_pkg::*;

	localparam int CW   = MAX_BITS_LOG2 + 1;
	localparam int MW   = $clog2(MAX_PATTERN + 1);
	localparam int CMDW = 1 + MAX_PATTERN + MW + CW;

	logic [3:0]      pattern_length_q;
	logic            init_done;
	logic            q_push, q_pop, q_full, q_empty;
	logic [CMDW-1:0] q_din, q_dout;

	// always ready: the user must write the register only between sequences; the block does not enforce it
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= PATTERN_LENGTH_RST;
		end else if (cfg_valid) begin
			pattern_length_q <= cfg_data;
		end
	end

	// front end: window, leading bits and bit count; emits increment and end commands
	stps_front #(
		.MAX_PATTERN   (MAX_PATTERN),
		.MAX_BITS_LOG2 (MAX_BITS_LOG2),
		.CMDW          (CMDW)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.pattern_length (pattern_length_q),
		.init_done      (init_done),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tlast        (s_tlast),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_din          (q_din)
	);

	// decouple the one-bit-a-cycle front from the slower memory back end
	stps_queue #(
		.WIDTH (CMDW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	// back end: count memory, end sweep, statistics and the result register
	stps_back #(
		.MAX_PATTERN   (MAX_PATTERN),
		.MAX_BITS_LOG2 (MAX_BITS_LOG2),
		.CMDW          (CMDW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.init_done (init_done),
		.q_empty   (q_empty),
		.q_dout    (q_dout),
		.q_pop     (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);
endmodule

>>> verif/stps_checker.sv
// Serial test statistics checker: watches the channels, predicts results and compares them.
`timescale 1ns / 1ps
module stps_checker
	import stps_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [3:0]             cfg_data,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [TDATA_IN_W-1:0]  s_tdata,
	input  logic                   s_tlast,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [TDATA_OUT_W-1:0] m_tdata,
	input  logic                   m_tuser,
	output int                     fail_count,
	output int                     pending,
	output int                     results_seen
);
	localparam int HIST_DEPTH = 1 << MAX_PATTERN_DEF;
	localparam int BIT_LIMIT  = 1 << MAX_BITS_LOG2_DEF;

	typedef struct packed {
		logic         too_short;
		stps_result_t stats;
	} stats_entry_t;

	logic [3:0]               length_reg;
	int unsigned              pattern_hist [HIST_DEPTH];
	logic [MAX_PATTERN_DEF-1:0] window_bits;
	logic [MAX_PATTERN_DEF-1:0] lead_bits;
	int unsigned              seen_bits;
	stats_entry_t             stats_q [$];

	function automatic longint unsigned scaled_psi(int m, int k, longint unsigned n);
		longint unsigned sum;
		longint unsigned c;
		int tail;
		if (k <= 0)
			return 0;
		sum = 0;
		tail = m - k;
		for (int p = 0; p < (1 << k); p++) begin
			c = 0;
			for (int s = 0; s < (1 << tail); s++)
				c += pattern_hist[((p << tail) | s) & (HIST_DEPTH - 1)];
			sum += c * c;
		end
		return (sum << k) - n * n;
	endfunction

	function void clear_sequence();
		foreach (pattern_hist[i])
			pattern_hist[i] = 0;
		window_bits = '0;
		lead_bits = '0;
		seen_bits = 0;
	endfunction

	// advance the predictor by one bit; push a result on the final bit
	function void take_bit(logic b, logic is_last);
		int m;
		longint unsigned n, p0, p1, p2;
		logic [MAX_PATTERN_DEF-1:0] w;
		stats_entry_t e;
		m = int'(length_reg);
		if (m < 1) m = 1;
		if (m > MAX_PATTERN_DEF) m = MAX_PATTERN_DEF;
		if (seen_bits < BIT_LIMIT) begin
			window_bits = {window_bits[MAX_PATTERN_DEF-2:0], b};
			if (seen_bits < MAX_PATTERN_DEF)
				lead_bits[seen_bits] = b;
			seen_bits++;
			if (seen_bits >= m)
				pattern_hist[int'(window_bits) & ((1 << m) - 1)]++;
		end
		if (!is_last)
			return;
		n = seen_bits;
		e = '0;
		e.stats.bit_count = n[20:0];
		if (n < m) begin
			e.too_short = 1'b1;
		end else begin
			w = window_bits;
			for (int j = 0; j + 1 < m; j++) begin
				w = {w[MAX_PATTERN_DEF-2:0], lead_bits[j]};
				pattern_hist[int'(w) & ((1 << m) - 1)]++;
			end
			p0 = scaled_psi(m, m, n);
			p1 = scaled_psi(m, m - 1, n);
			p2 = scaled_psi(m, m - 2, n);
			e.stats.psi_m_scaled = p0[53:0];
			e.stats.psi_m1_scaled = p1[53:0];
			e.stats.psi_m2_scaled = p2[53:0];
			e.stats.first_delta_scaled = 56'(p0 - p1);
			e.stats.second_delta_scaled = 56'(p0 - 2 * p1 + p2);
		end
		stats_q.push_back(e);
		clear_sequence();
	endfunction

	always @(posedge clk or negedge arst_n) begin
		stats_entry_t exp_e;
		stps_result_t got;
		logic bad;
		if (!arst_n) begin
			length_reg = PATTERN_LENGTH_RST;
			clear_sequence();
			stats_q.delete();
			fail_count = 0;
			results_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				length_reg = cfg_data;
			if (s_tvalid && s_tready)
				take_bit(s_tdata[0], s_tlast);
			if (m_tvalid && m_tready) begin
				results_seen++;
				got = stps_result_t'(m_tdata);
				if (stats_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("ERROR: result with none expected, n=%0d", got.bit_count);
				end else begin
					exp_e = stats_q.pop_front();
					bad = (got.psi_m_scaled != exp_e.stats.psi_m_scaled)
						|| (got.psi_m1_scaled != exp_e.stats.psi_m1_scaled)
						|| (got.psi_m2_scaled != exp_e.stats.psi_m2_scaled)
						|| (got.first_delta_scaled != exp_e.stats.first_delta_scaled)
						|| (got.second_delta_scaled != exp_e.stats.second_delta_scaled)
						|| (got.bit_count != exp_e.stats.bit_count)
						|| (m_tuser !== exp_e.too_short);
					if (bad) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("ERROR: exp psi %0d %0d %0d d1 %0d d2 %0d n %0d short %0d",
								exp_e.stats.psi_m_scaled, exp_e.stats.psi_m1_scaled,
								exp_e.stats.psi_m2_scaled,
								$signed(exp_e.stats.first_delta_scaled),
								$signed(exp_e.stats.second_delta_scaled),
								exp_e.stats.bit_count, exp_e.too_short);
							$display("       got psi %0d %0d %0d d1 %0d d2 %0d n %0d short %0d",
								got.psi_m_scaled, got.psi_m1_scaled, got.psi_m2_scaled,
								$signed(got.first_delta_scaled),
								$signed(got.second_delta_scaled), got.bit_count, m_tuser);
						end
					end
				end
			end
		end
		pending = stats_q.size();
	end
endmodule

>>> verif/testbench.sv
// Testbench top for the serial test pattern statistics unit: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module testbench;
	import stps_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int ITEM_TARGET = 1450;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [3:0]             cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [TDATA_IN_W-1:0]  s_tdata;
	logic                   s_tlast;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [TDATA_OUT_W-1:0] m_tdata;
	logic                   m_tuser;

	int fail_count;
	int pending;
	int results_seen;
	int bits_sent;
	int sequences_sent;
	int settings_used;
	int burst_left;

	// receiver stall state
	int          stall_mode;
	int          stall_tick;
	logic [15:0] stall_pat;

	serial_test_pattern_statistics_unit uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	stps_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.fail_count(fail_count), .pending(pending), .results_seen(results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: switch between always ready, coin-flip and a rotating pattern
	always @(negedge clk) begin
		stall_tick <= stall_tick + 1;
		if (stall_tick % 97 == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_pat <= 16'($urandom);
		end else begin
			stall_pat <= {stall_pat[14:0], stall_pat[15]};
		end
		case (stall_mode)
			0: begin
				m_tready <= 1'b1;
			end
			1: begin
				m_tready <= 1'($urandom_range(0, 1));
			end
			default: begin
				m_tready <= stall_pat[0];
			end
		endcase
	end

	// watchdog
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Test completed with failures");
		$finish;
	end

	// hold the request until taken; open a new burst, sometimes after a random gap
	task send_bit(input logic b, input logic is_last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(TDATA_IN_W - 1){1'b0}}, b};
		s_tlast <= is_last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		burst_left--;
		bits_sent++;
	endtask

	// content: 0 random, 1 all zeros, 2 all ones, 3 alternating
	task send_sequence(input int len, input int content);
		logic b;
		for (int i = 0; i < len; i++) begin
			case (content)
				1: b = 1'b0;
				2: b = 1'b1;
				3: b = i[0];
				default: b = 1'($urandom_range(0, 1));
			endcase
			send_bit(b, i == len - 1);
		end
		s_tvalid <= 1'b0;
		s_tlast <= 1'b0;
		sequences_sent++;
	endtask

	// drain every result, let the end sweep settle, then write the length
	task write_length(input logic [3:0] value);
		while (pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	initial begin
		int lengths [16];
		int m;
		int idx;
		lengths = '{0, 1, 2, 12, 15, 13, 4, 7, 5, 9, 11, 6, 3, 8, 10, 14};
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		stall_mode = 0;
		stall_tick = 1;
		stall_pat = 16'hA5C3;
		bits_sent = 0;
		sequences_sent = 0;
		settings_used = 1;
		burst_left = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset length 3, short, exact and flat sequences
		send_sequence(1, 2);
		send_sequence(2, 0);
		send_sequence(3, 2);
		send_sequence(3, 1);
		send_sequence(4, 3);
		send_sequence(12, 2);

		// random phases, walking through every length setting at least once
		idx = 0;
		while (idx < 16 || bits_sent < ITEM_TARGET) begin
			write_length(4'(lengths[idx % 16]));
			m = lengths[idx % 16];
			if (m < 1) m = 1;
			if (m > MAX_PATTERN_DEF) m = MAX_PATTERN_DEF;
			if (m > 1)
				send_sequence(m - 1, 0);
			send_sequence(m, $urandom_range(0, 3));
			for (int k = 0; k < 3; k++) begin
				if ($urandom_range(0, 9) == 0)
					send_sequence($urandom_range(60, 160), 0);
				else
					send_sequence($urandom_range(1, 30), ($urandom_range(0, 7) == 0) ?
						$urandom_range(1, 3) : 0);
			end
			idx++;
		end

		while (pending != 0)
			@(negedge clk);
		repeat (50) @(negedge clk);
		$display("Sent %0d bits in %0d sequences over %0d length settings.",
			bits_sent, sequences_sent, settings_used);
		$display("Checked %0d results, %0d mismatches.", results_seen, fail_count);
		if (fail_count == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

>>> filelist.f
hw/rtl/stps_pkg.sv
hw/rtl/stps_queue.sv
hw/rtl/stps_front.sv
hw/rtl/stps_back.sv
hw/rtl/serial_test_pattern_statistics_unit.sv
verif/stps_checker.sv
verif/testbench.sv
